// ----- rtl/fdrl_pkg.sv -----
// Shared types, codes and helpers for the debounced fault latch.
// Used by fault_debounce_recover_latch and its port checker; no dependencies.
package fdrl_pkg;

    localparam int NCHAN    = 3;
    localparam int TMR_W    = 26;
    localparam int MS_W     = 16;
    localparam int CFG_IDX_W = 3;

    // stream payload layout
    localparam int S_TDATA_W = 24;
    localparam int S_TUSER_W = 2;
    localparam int M_TDATA_W = 16;

    typedef enum logic [1:0] {
        ACT_TICK    = 2'd0,
        ACT_CLR_ONE = 2'd1,
        ACT_CLR_ALL = 2'd2
    } action_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_CHAN_EN    = 3'd0,
        REG_OV_TRIP    = 3'd1,
        REG_UV_TRIP    = 3'd2,
        REG_STALL_TRIP = 3'd3,
        REG_OV_CLR     = 3'd4,
        REG_UV_CLR     = 3'd5,
        REG_STALL_CLR  = 3'd6
    } cfg_idx_t;

    localparam logic [NCHAN-1:0] CHAN_EN_RST    = 3'b111;
    localparam logic [MS_W-1:0]  OV_TRIP_RST    = 16'd200;
    localparam logic [MS_W-1:0]  UV_TRIP_RST    = 16'd200;
    localparam logic [MS_W-1:0]  STALL_TRIP_RST = 16'd500;
    localparam logic [MS_W-1:0]  OV_CLR_RST     = 16'd1000;
    localparam logic [MS_W-1:0]  UV_CLR_RST     = 16'd1000;
    localparam logic [MS_W-1:0]  STALL_CLR_RST  = 16'd5000;

    // ms * 1000 as 1024 - 16 - 8; the result stays below 2^26
    function automatic logic [TMR_W-1:0] ms_to_us(input logic [MS_W-1:0] ms);
        logic [TMR_W-1:0] m;
        m = {{(TMR_W-MS_W){1'b0}}, ms};
        return (m << 10) - (m << 4) - (m << 3);
    endfunction

    // add and clamp at the top of the timer range
    function automatic logic [TMR_W-1:0] add_sat(input logic [TMR_W-1:0] a,
                                                 input logic [MS_W-1:0]  b);
        logic [TMR_W:0] s;
        s = {1'b0, a} + {{(TMR_W+1-MS_W){1'b0}}, b};
        return s[TMR_W] ? {TMR_W{1'b1}} : s[TMR_W-1:0];
    endfunction

endpackage

// ----- rtl/fault_debounce_recover_latch.sv -----
// A request moves from the input register into the result register once that register is empty or draining.
// Throughput: one request per cycle; the input register refills while the
// result register drains, so only a stalled m_tready holds s_tready low.
// Reset (aresetn low, synchronous) empties both registers, clears latches and
// timers and restores the register defaults.
// Top level of the debounced fault latch; depends on fdrl_pkg.
module fault_debounce_recover_latch (
    input  logic                                aclk,
    input  logic                                aresetn,
    // configuration write port
    input  logic                                cfg_we,
    input  logic [fdrl_pkg::CFG_IDX_W-1:0]      cfg_addr,
    input  logic [fdrl_pkg::MS_W-1:0]           cfg_wdata,
    // request channel
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // s_tdata: cond_bits[2:0] elapsed_us[18:3] channel[20:19]
    input  logic [fdrl_pkg::S_TDATA_W-1:0]      s_tdata,
    input  logic [fdrl_pkg::S_TUSER_W-1:0]      s_tuser,  // action[1:0]
    // result channel
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // m_tdata: fault_bits[2:0] any_fault[3] tripped_bits[6:4] recovered_bits[9:7]
    output logic [fdrl_pkg::M_TDATA_W-1:0]      m_tdata
);

    localparam int N  = fdrl_pkg::NCHAN;
    localparam int TW = fdrl_pkg::TMR_W;

    // configuration
    logic [N-1:0]  chan_en_reg;
    logic [TW-1:0] trip_thr_reg [N];
    logic [TW-1:0] clr_thr_reg  [N];

    // input register
    logic                         in_valid_reg;
    fdrl_pkg::action_t            act_reg;
    logic [N-1:0]                 cond_reg;
    logic [fdrl_pkg::MS_W-1:0]    dt_reg;
    logic [1:0]                   chan_reg;

    // channel state
    logic [N-1:0]  lat_reg, lat_next;
    logic [TW-1:0] trip_tmr_reg [N];
    logic [TW-1:0] trip_tmr_next[N];
    logic [TW-1:0] clr_tmr_reg  [N];
    logic [TW-1:0] clr_tmr_next [N];
    logic [N-1:0]  tripped, recovered;

    // result register
    logic                         out_valid_reg;
    logic [fdrl_pkg::M_TDATA_W-1:0] out_data_reg;

    logic advance;

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            chan_en_reg     <= fdrl_pkg::CHAN_EN_RST;
            trip_thr_reg[0] <= fdrl_pkg::ms_to_us(fdrl_pkg::OV_TRIP_RST);
            trip_thr_reg[1] <= fdrl_pkg::ms_to_us(fdrl_pkg::UV_TRIP_RST);
            trip_thr_reg[2] <= fdrl_pkg::ms_to_us(fdrl_pkg::STALL_TRIP_RST);
            clr_thr_reg[0]  <= fdrl_pkg::ms_to_us(fdrl_pkg::OV_CLR_RST);
            clr_thr_reg[1]  <= fdrl_pkg::ms_to_us(fdrl_pkg::UV_CLR_RST);
            clr_thr_reg[2]  <= fdrl_pkg::ms_to_us(fdrl_pkg::STALL_CLR_RST);
        end else if (cfg_we) begin
            // hold thresholds in microseconds; a zero recovery threshold stays zero
            case (cfg_addr)
                fdrl_pkg::REG_CHAN_EN:    chan_en_reg     <= cfg_wdata[N-1:0];
                fdrl_pkg::REG_OV_TRIP:    trip_thr_reg[0] <= fdrl_pkg::ms_to_us(cfg_wdata);
                fdrl_pkg::REG_UV_TRIP:    trip_thr_reg[1] <= fdrl_pkg::ms_to_us(cfg_wdata);
                fdrl_pkg::REG_STALL_TRIP: trip_thr_reg[2] <= fdrl_pkg::ms_to_us(cfg_wdata);
                fdrl_pkg::REG_OV_CLR:     clr_thr_reg[0]  <= fdrl_pkg::ms_to_us(cfg_wdata);
                fdrl_pkg::REG_UV_CLR:     clr_thr_reg[1]  <= fdrl_pkg::ms_to_us(cfg_wdata);
                fdrl_pkg::REG_STALL_CLR:  clr_thr_reg[2]  <= fdrl_pkg::ms_to_us(cfg_wdata);
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            act_reg  <= fdrl_pkg::action_t'(s_tuser[1:0]);
            cond_reg <= s_tdata[2:0];
            dt_reg   <= s_tdata[18:3];
            chan_reg <= s_tdata[20:19];
        end
    end

    always_comb begin
        logic [TW-1:0] sum;
        lat_next  = lat_reg;
        tripped   = '0;
        recovered = '0;
        sum       = '0;
        for (int i = 0; i < N; i++) begin
            trip_tmr_next[i] = trip_tmr_reg[i];
            clr_tmr_next[i]  = clr_tmr_reg[i];
            case (act_reg)
                fdrl_pkg::ACT_TICK: begin
                    if (dt_reg != '0 && chan_en_reg[i]) begin
                        if (cond_reg[i]) begin
                            if (!lat_reg[i]) begin
                                sum = fdrl_pkg::add_sat(trip_tmr_reg[i], dt_reg);
                                if (sum >= trip_thr_reg[i]) begin
                                    lat_next[i]      = 1'b1;
                                    trip_tmr_next[i] = '0;
                                    tripped[i]       = 1'b1;
                                end else begin
                                    trip_tmr_next[i] = sum;
                                end
                            end
                        end else begin
                            trip_tmr_next[i] = '0;
                            if (lat_reg[i] && clr_thr_reg[i] != '0) begin
                                sum = fdrl_pkg::add_sat(clr_tmr_reg[i], dt_reg);
                                if (sum >= clr_thr_reg[i]) begin
                                    lat_next[i]     = 1'b0;
                                    clr_tmr_next[i] = '0;
                                    recovered[i]    = 1'b1;
                                end else begin
                                    clr_tmr_next[i] = sum;
                                end
                            end
                        end
                    end
                end
                fdrl_pkg::ACT_CLR_ONE: begin
                    if (chan_reg == 2'(i)) begin
                        lat_next[i]      = 1'b0;
                        trip_tmr_next[i] = '0;
                        clr_tmr_next[i]  = '0;
                    end
                end
                fdrl_pkg::ACT_CLR_ALL: begin
                    lat_next[i]      = 1'b0;
                    trip_tmr_next[i] = '0;
                    clr_tmr_next[i]  = '0;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lat_reg <= '0;
            for (int i = 0; i < N; i++) begin
                trip_tmr_reg[i] <= '0;
                clr_tmr_reg[i]  <= '0;
            end
        end else if (advance) begin
            lat_reg <= lat_next;
            for (int i = 0; i < N; i++) begin
                trip_tmr_reg[i] <= trip_tmr_next[i];
                clr_tmr_reg[i]  <= clr_tmr_next[i];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_data_reg <= {6'b0, recovered, tripped, |lat_next, lat_next};
        end
    end

endmodule

// ----- rtl/fdrl_checker.sv -----
// Port-level checks for fault_debounce_recover_latch, attached by bind.
// Depends on fdrl_pkg for the payload widths.
module fdrl_checker (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [fdrl_pkg::M_TDATA_W-1:0] m_tdata
);

    logic [2:0] faults;
    logic [2:0] trips;
    logic [2:0] recs;

    assign faults = m_tdata[2:0];
    assign trips  = m_tdata[6:4];
    assign recs   = m_tdata[9:7];

    // summary bit follows the bitmap
    a_any_fault: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[3] == (faults != 3'b000)))
        else $error("any_fault disagrees with fault_bits");

    // a channel that latched this step must be in the bitmap, one that recovered must not
    a_edges: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (((trips & ~faults) == 3'b000) && ((recs & faults) == 3'b000)))
        else $error("trip or recovery flag inconsistent with fault_bits");

    a_no_both: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> ((trips & recs) == 3'b000))
        else $error("channel both tripped and recovered");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid straight after reset");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("stalled result dropped or changed");

endmodule

bind fault_debounce_recover_latch fdrl_checker u_fdrl_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

// ----- verif/tb_top.sv -----
// Self-checking testbench for fault_debounce_recover_latch: predicts every result
// from its own model of the three debounce/recovery channels and checks each one.
// Depends on fdrl_pkg and the RTL top level only.
import fdrl_pkg::*;

class fault_latch_scoreboard;
    typedef struct {
        logic [NCHAN-1:0] faults;
        logic             any_fault;
        logic [NCHAN-1:0] tripped;
        logic [NCHAN-1:0] recovered;
    } latch_result_t;

    localparam logic [TMR_W-1:0] TMR_MAX = '1;

    logic [NCHAN-1:0] chan_en;
    logic [MS_W-1:0]  trip_ms[NCHAN];
    logic [MS_W-1:0]  clear_ms[NCHAN];
    logic             latched[NCHAN];
    logic [TMR_W-1:0] trip_us[NCHAN];
    logic [TMR_W-1:0] clear_us[NCHAN];
    latch_result_t    fault_q[$];
    int               n_err;

    function new();
        chan_en     = CHAN_EN_RST;
        trip_ms[0]  = OV_TRIP_RST;
        trip_ms[1]  = UV_TRIP_RST;
        trip_ms[2]  = STALL_TRIP_RST;
        clear_ms[0] = OV_CLR_RST;
        clear_ms[1] = UV_CLR_RST;
        clear_ms[2] = STALL_CLR_RST;
        for (int i = 0; i < NCHAN; i++) clear_chan(i);
        n_err = 0;
    endfunction

    function void report(string what);
        $display("ERROR: %s", what);
        n_err++;
    endfunction

    function void clear_chan(int i);
        latched[i]  = 1'b0;
        trip_us[i]  = '0;
        clear_us[i] = '0;
    endfunction

    function void set_reg(cfg_idx_t idx, logic [MS_W-1:0] value);
        case (idx)
            REG_CHAN_EN:    chan_en     = value[NCHAN-1:0];
            REG_OV_TRIP:    trip_ms[0]  = value;
            REG_UV_TRIP:    trip_ms[1]  = value;
            REG_STALL_TRIP: trip_ms[2]  = value;
            REG_OV_CLR:     clear_ms[0] = value;
            REG_UV_CLR:     clear_ms[1] = value;
            REG_STALL_CLR:  clear_ms[2] = value;
            default: ;
        endcase
    endfunction

    // timers count microseconds and clamp at the top of their range
    function logic [TMR_W-1:0] add_clamped(logic [TMR_W-1:0] acc, logic [MS_W-1:0] dt);
        logic [TMR_W:0] sum;
        sum = {1'b0, acc} + {{(TMR_W+1-MS_W){1'b0}}, dt};
        return sum[TMR_W] ? TMR_MAX : sum[TMR_W-1:0];
    endfunction

    function logic [TMR_W-1:0] ms_limit(logic [MS_W-1:0] ms);
        return {{(TMR_W-MS_W){1'b0}}, ms} * 26'd1000;
    endfunction

    function void note_request(logic [1:0] act, logic [NCHAN-1:0] cond,
                               logic [MS_W-1:0] dt, logic [1:0] chan);
        latch_result_t r;
        r.tripped   = '0;
        r.recovered = '0;
        if (act == ACT_TICK && dt != 0) begin
            for (int i = 0; i < NCHAN; i++) begin
                if (!chan_en[i]) continue;
                if (cond[i]) begin
                    // a latched channel keeps its recovery time while the fault persists
                    if (!latched[i]) begin
                        trip_us[i] = add_clamped(trip_us[i], dt);
                        if (trip_us[i] >= ms_limit(trip_ms[i])) begin
                            latched[i]   = 1'b1;
                            trip_us[i]   = '0;
                            r.tripped[i] = 1'b1;
                        end
                    end
                end else begin
                    trip_us[i] = '0;
                    if (latched[i] && clear_ms[i] != 0) begin
                        clear_us[i] = add_clamped(clear_us[i], dt);
                        if (clear_us[i] >= ms_limit(clear_ms[i])) begin
                            latched[i]     = 1'b0;
                            clear_us[i]    = '0;
                            r.recovered[i] = 1'b1;
                        end
                    end
                end
            end
        end else if (act == ACT_CLR_ONE) begin
            if (chan < NCHAN) clear_chan(chan);
        end else if (act == ACT_CLR_ALL) begin
            for (int i = 0; i < NCHAN; i++) clear_chan(i);
        end
        for (int i = 0; i < NCHAN; i++) r.faults[i] = latched[i];
        r.any_fault = |r.faults;
        fault_q.push_back(r);
    endfunction

    function void check_result(logic [M_TDATA_W-1:0] data);
        latch_result_t e;
        if (fault_q.size() == 0) begin
            report($sformatf("result 0x%04h with no request pending", data));
            return;
        end
        e = fault_q.pop_front();
        if (data[2:0] !== e.faults)
            report($sformatf("fault_bits %0d, expected %0d", data[2:0], e.faults));
        if (data[3] !== e.any_fault)
            report($sformatf("any_fault %0d, expected %0d", data[3], e.any_fault));
        if (data[6:4] !== e.tripped)
            report($sformatf("tripped_bits %0d, expected %0d", data[6:4], e.tripped));
        if (data[9:7] !== e.recovered)
            report($sformatf("recovered_bits %0d, expected %0d", data[9:7], e.recovered));
    endfunction
endclass

module tb_top;
    localparam logic [1:0] ACT_RSVD    = 2'd3;
    localparam logic [1:0] CHAN_RSVD   = 2'd3;
    localparam int         CYCLE_LIMIT = 100000;
    localparam int         HOLD_CYCLES = 300;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_addr  = '0;
    logic [MS_W-1:0]       cfg_wdata = '0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata   = '0;
    logic [S_TUSER_W-1:0]  s_tuser   = '0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;

    fault_latch_scoreboard sb;

    bit               tx_idle   = 1'b1;
    bit               rx_idle   = 1'b1;
    int               hold_req  = 0;
    int               hold_left = 0;
    int               rx_stall  = 0;
    int               cycles    = 0;
    logic [NCHAN-1:0] cond_now  = '0;
    logic [NCHAN-1:0] cfg_en;
    logic [MS_W-1:0]  cfg_trip[NCHAN];
    logic [MS_W-1:0]  cfg_clear[NCHAN];

    fault_debounce_recover_latch u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("FAILED: results differ");
            $finish;
        end
    end

    // note accepted requests and check accepted results at the same edge
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready)
                sb.note_request(s_tuser, s_tdata[2:0], s_tdata[18:3], s_tdata[20:19]);
            if (m_tvalid && m_tready)
                sb.check_result(m_tdata);
        end
    end

    // result side: random stall per result, plus a long hold-off on request
    always @(posedge aclk) begin
        if (hold_req != 0) begin
            hold_left = hold_req;
            hold_req  = 0;
        end
        if (m_tvalid && m_tready)
            rx_stall = rx_idle ? $urandom_range(0, 6) : 0;
        if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else if (rx_stall > 0) begin
            rx_stall--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    task automatic send_request(logic [1:0] act, logic [NCHAN-1:0] cond,
                                logic [MS_W-1:0] dt, logic [1:0] chan);
        int gap;
        gap = tx_idle ? $urandom_range(0, 6) : 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= act;
        s_tdata  <= {3'b000, chan, dt, cond};
        do @(posedge aclk); while (!s_tready);
    endtask

    // wait for a clock edge first so the last accepted request is already queued
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (sb.fault_q.size() != 0) @(posedge aclk);
    endtask

    task automatic write_reg(cfg_idx_t idx, logic [MS_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= value;
        @(posedge aclk);
        sb.set_reg(idx, value);
    endtask

    task automatic apply_config();
        write_reg(REG_CHAN_EN,    {{(MS_W-NCHAN){1'b0}}, cfg_en});
        write_reg(REG_OV_TRIP,    cfg_trip[0]);
        write_reg(REG_UV_TRIP,    cfg_trip[1]);
        write_reg(REG_STALL_TRIP, cfg_trip[2]);
        write_reg(REG_OV_CLR,     cfg_clear[0]);
        write_reg(REG_UV_CLR,     cfg_clear[1]);
        write_reg(REG_STALL_CLR,  cfg_clear[2]);
        cfg_we <= 1'b0;
    endtask

    function automatic logic [MS_W-1:0] pick_elapsed();
        int sel;
        sel = $urandom_range(0, 19);
        if (sel == 0)  return '0;
        if (sel == 1)  return '1;
        if (sel < 10)  return 16'($urandom_range(1, 1500));
        if (sel < 16)  return 16'(1000 * $urandom_range(1, 5));
        return 16'($urandom_range(0, 65535));
    endfunction

    // mostly ticks whose conditions persist for a while, some clears and noise
    task automatic run_phase(int n_items, int hold_at, int pause_at);
        int sel;
        for (int n = 0; n < n_items; n++) begin
            if (n == hold_at) hold_req = HOLD_CYCLES;
            if (n == pause_at) wait_drained();
            for (int i = 0; i < NCHAN; i++)
                if ($urandom_range(0, 3) == 0) cond_now[i] = ~cond_now[i];
            sel = $urandom_range(0, 99);
            if (sel < 82)
                send_request(ACT_TICK, cond_now, pick_elapsed(), 2'($urandom_range(0, 3)));
            else if (sel < 90)
                send_request(ACT_CLR_ONE, 3'($urandom_range(0, 7)), pick_elapsed(),
                             2'($urandom_range(0, 3)));
            else if (sel < 94)
                send_request(ACT_CLR_ALL, 3'($urandom_range(0, 7)), pick_elapsed(),
                             2'($urandom_range(0, 3)));
            else if (sel < 97)
                send_request(ACT_RSVD, 3'($urandom_range(0, 7)), pick_elapsed(),
                             2'($urandom_range(0, 3)));
            else
                send_request(ACT_TICK, 3'($urandom_range(0, 7)), pick_elapsed(),
                             2'($urandom_range(0, 3)));
        end
        wait_drained();
    endtask

    initial begin
        sb = new();
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset defaults: long debounce, and a zero tick
        send_request(ACT_TICK, 3'b111, 16'hFFFF, 2'd0);
        send_request(ACT_TICK, 3'b111, 16'h0000, 2'd1);
        wait_drained();

        // zero debounce on over, 1 ms and 2 ms on the others; under never recovers
        cfg_en       = 3'b111;
        cfg_trip[0]  = 16'd0;
        cfg_trip[1]  = 16'd1;
        cfg_trip[2]  = 16'd2;
        cfg_clear[0] = 16'd1;
        cfg_clear[1] = 16'd0;
        cfg_clear[2] = 16'd2;
        apply_config();
        send_request(ACT_CLR_ALL, 3'b000, 16'h0000, 2'd0);
        send_request(ACT_TICK,    3'b111, 16'd1,    2'd0);
        send_request(ACT_TICK,    3'b111, 16'd1000, 2'd0);
        send_request(ACT_TICK,    3'b011, 16'hFFFF, 2'd2);
        send_request(ACT_TICK,    3'b100, 16'd500,  2'd0);
        // fault back while latched: recovery time is held, not reset
        send_request(ACT_TICK,    3'b101, 16'd600,  2'd0);
        send_request(ACT_TICK,    3'b100, 16'd500,  2'd0);
        send_request(ACT_TICK,    3'b100, 16'd400,  2'd0);
        send_request(ACT_CLR_ONE, 3'b111, 16'hFFFF, 2'd2);
        send_request(ACT_CLR_ONE, 3'b111, 16'hFFFF, CHAN_RSVD);
        send_request(ACT_RSVD,    3'b111, 16'hFFFF, CHAN_RSVD);
        send_request(ACT_TICK,    3'b111, 16'd1,    2'd1);
        send_request(ACT_CLR_ONE, 3'b000, 16'd0,    2'd0);
        send_request(ACT_CLR_ONE, 3'b000, 16'd0,    2'd1);
        send_request(ACT_CLR_ALL, 3'b111, 16'hFFFF, 2'd3);
        wait_drained();

        // under disabled: its state must stay frozen
        cfg_en = 3'b101;
        apply_config();
        send_request(ACT_TICK, 3'b111, 16'd2000, 2'd0);
        send_request(ACT_TICK, 3'b000, 16'd1000, 2'd0);
        send_request(ACT_TICK, 3'b010, 16'd3000, 2'd0);
        wait_drained();

        for (int p = 0; p < 8; p++) begin
            tx_idle = (p != 1 && p != 2);
            rx_idle = (p != 1);
            cfg_en  = 3'($urandom_range(0, 7));
            for (int i = 0; i < NCHAN; i++) begin
                cfg_trip[i]  = 16'($urandom_range(0, 6));
                cfg_clear[i] = 16'($urandom_range(0, 12));
            end
            case (p)
                0: cfg_en = 3'b111;
                3: begin
                    cfg_en = 3'b111;
                    for (int i = 0; i < NCHAN; i++) begin
                        cfg_trip[i]  = '1;
                        cfg_clear[i] = '1;
                    end
                end
                5: cfg_en = 3'b000;
                6: begin
                    cfg_en = 3'b111;
                    for (int i = 0; i < NCHAN; i++) begin
                        cfg_trip[i]  = '0;
                        cfg_clear[i] = '0;
                    end
                end
                7: begin
                    cfg_trip[0]  = OV_TRIP_RST;
                    cfg_trip[1]  = UV_TRIP_RST;
                    cfg_trip[2]  = STALL_TRIP_RST;
                    cfg_clear[0] = OV_CLR_RST;
                end
                default: ;
            endcase
            apply_config();
            case (p)
                2:       run_phase(70, 20, -1);
                3:       run_phase(30, -1, -1);
                4:       run_phase(70, -1, 35);
                5:       run_phase(20, -1, -1);
                default: run_phase(70, -1, -1);
            endcase
        end

        wait_drained();
        repeat (8) @(posedge aclk);
        if (sb.fault_q.size() != 0)
            sb.report($sformatf("%0d results never arrived", sb.fault_q.size()));
        if (sb.n_err == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end
endmodule
